### hw/rtl/frame_silence_record_gate_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the frame silence record gate
// Concurrent checks that vanish from synthesis builds.
// ----------------------------------------------------------------------------
`ifndef FRAME_SILENCE_RECORD_GATE_UNIT_MACROS_SVH
`define FRAME_SILENCE_RECORD_GATE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a condition implies another in the same cycle
`define FSRG_ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");

// Check that a condition implies another in the next cycle
`define FSRG_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");

`else

`define FSRG_ASSERT_IMPLIES(label, clk, rst_n, cond, prop)
`define FSRG_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

### hw/rtl/fsrg_pkg.sv
// ----------------------------------------------------------------------------
// fsrg_pkg
// Shared types, register indexes and reset values of the frame gate.
// ----------------------------------------------------------------------------
package fsrg_pkg;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LOUD_THRESHOLD    = 2'd0,
        CFG_FRAME_LENGTH      = 2'd1,
        CFG_MIN_LOUD_COUNT    = 2'd2,
        CFG_STOP_AFTER_SILENT = 2'd3
    } t_cfg_index;

    localparam logic [14:0] RST_LOUD_THRESHOLD    = 15'd32767;
    localparam logic [15:0] RST_FRAME_LENGTH      = 16'd22050;
    localparam logic [15:0] RST_MIN_LOUD_COUNT    = 16'd5512;
    localparam logic [7:0]  RST_STOP_AFTER_SILENT = 8'd20;

    typedef struct packed {
        logic [14:0] loud_threshold;
        logic [15:0] frame_length;
        logic [15:0] min_loud_count;
        logic [7:0]  stop_after_silent;
    } t_cfg;

    typedef struct packed {
        logic        frame_silent;
        logic        start_recording;
        logic        keep_frame;
        logic        stop_recording;
        logic [15:0] loud_count;
    } t_result;

endpackage

### hw/rtl/fsrg_cfg_regs.sv
// ----------------------------------------------------------------------------
// fsrg_cfg_regs
// Configuration register file, write only, one register per index.
// ----------------------------------------------------------------------------
module fsrg_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [fsrg_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [fsrg_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output fsrg_pkg::t_cfg                 o_cfg
);
    import fsrg_pkg::*;

    t_cfg r_cfg;

    // Write the addressed register, keeping only its low bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.loud_threshold    <= RST_LOUD_THRESHOLD;
            r_cfg.frame_length      <= RST_FRAME_LENGTH;
            r_cfg.min_loud_count    <= RST_MIN_LOUD_COUNT;
            r_cfg.stop_after_silent <= RST_STOP_AFTER_SILENT;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_LOUD_THRESHOLD:    r_cfg.loud_threshold    <= i_cfg_data[14:0];
                CFG_FRAME_LENGTH:      r_cfg.frame_length      <= i_cfg_data[15:0];
                CFG_MIN_LOUD_COUNT:    r_cfg.min_loud_count    <= i_cfg_data[15:0];
                CFG_STOP_AFTER_SILENT: r_cfg.stop_after_silent <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hw/rtl/fsrg_frame_stage.sv
// ----------------------------------------------------------------------------
// fsrg_frame_stage
// Per-sample loudness count, frame boundary and recording decision.
// ----------------------------------------------------------------------------
module fsrg_frame_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [15:0]       i_sample,
    input  fsrg_pkg::t_cfg    i_cfg,
    output logic              o_frame_end,
    output fsrg_pkg::t_result o_result
);
    import fsrg_pkg::*;

    logic [15:0] r_position;
    logic [15:0] r_loud_tally;
    logic        r_recording;
    logic [7:0]  r_silent_tally;

    logic [15:0] n_position;
    logic [15:0] n_loud_tally;
    logic        n_recording;
    logic [7:0]  n_silent_tally;

    logic [16:0] mag;
    logic        loud;
    logic [15:0] count;
    logic [16:0] taken;
    logic        silent;
    logic        start;
    logic        rec_mid;
    logic [7:0]  silent_base;
    logic [7:0]  silent_inc;
    logic        stop;

    // Magnitude of the sample; the most negative value gives 32768
    always_comb begin
        mag  = i_sample[15] ? (17'h10000 - {1'b0, i_sample}) : {1'b0, i_sample};
        loud = mag >= {2'b00, i_cfg.loud_threshold};
    end

    // Count loud samples, saturating, and find the frame boundary
    always_comb begin
        count       = r_loud_tally + {15'd0, (loud && (r_loud_tally != 16'hFFFF))};
        taken       = {1'b0, r_position} + 17'd1;
        o_frame_end = !(taken < {1'b0, i_cfg.frame_length});
    end

    // Decide on recording at the frame end
    always_comb begin
        silent      = count < i_cfg.min_loud_count;
        start       = !r_recording && !silent;
        rec_mid     = r_recording || start;
        silent_base = start ? 8'd0 : r_silent_tally;
        silent_inc  = (silent_base != 8'hFF) ? (silent_base + 8'd1) : silent_base;
        stop        = rec_mid && silent && (silent_inc >= i_cfg.stop_after_silent);
    end

    // Next state: advance within a frame, or close it
    always_comb begin
        n_position     = r_position;
        n_loud_tally   = r_loud_tally;
        n_recording    = r_recording;
        n_silent_tally = r_silent_tally;
        if (i_step) begin
            if (!o_frame_end) begin
                n_position   = taken[15:0];
                n_loud_tally = count;
            end else begin
                n_position   = 16'd0;
                n_loud_tally = 16'd0;
                n_recording  = rec_mid && !stop;
                if (rec_mid) begin
                    n_silent_tally = silent ? silent_inc : silent_base;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position     <= 16'd0;
            r_loud_tally   <= 16'd0;
            r_recording    <= 1'b0;
            r_silent_tally <= 8'd0;
        end else begin
            r_position     <= n_position;
            r_loud_tally   <= n_loud_tally;
            r_recording    <= n_recording;
            r_silent_tally <= n_silent_tally;
        end
    end

    assign o_result.frame_silent    = silent;
    assign o_result.start_recording = start;
    assign o_result.keep_frame      = rec_mid;
    assign o_result.stop_recording  = stop;
    assign o_result.loud_count      = count;

endmodule

### hw/rtl/frame_silence_record_gate_unit.sv
// ----------------------------------------------------------------------------
// frame_silence_record_gate_unit
// Frame-based voice activity gate with hangover: one decision per frame.
// ----------------------------------------------------------------------------
// Samples are taken at one item per clock, except while a sample that
// closes a frame is held. Each accepted sample goes into an input
// register and is counted against the frame from there; a frame's
// decision is loaded into the output register when its closing sample
// is processed. Samples that do not close a frame produce no item and
// never wait for the output side. A sample that closes a frame waits
// only while the previous decision is still held unread.
// ----------------------------------------------------------------------------
module frame_silence_record_gate_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic signed [15:0]               i_sample,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_frame_silent,
    output logic                             o_start_recording,
    output logic                             o_keep_frame,
    output logic                             o_stop_recording,
    output logic [15:0]                      o_loud_count,
    input  logic                             i_cfg_we,
    input  logic [fsrg_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [fsrg_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import fsrg_pkg::*;

`include "frame_silence_record_gate_unit_macros.svh"

    t_cfg        cfg;
    t_result     result;
    t_result     r_out;
    logic        r_out_valid;
    logic        r_in_valid;
    logic [15:0] r_sample;
    logic        frame_end;
    logic        slot_free;
    logic        step;

    fsrg_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    fsrg_frame_stage u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_sample    (r_sample),
        .i_cfg       (cfg),
        .o_frame_end (frame_end),
        .o_result    (result)
    );

    // Process the held sample unless it closes a frame with the output full
    assign slot_free = !r_out_valid || i_ready;
    assign step      = r_in_valid && (!frame_end || slot_free);
    assign o_ready   = !r_in_valid || step;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_sample <= i_sample;
        end
    end

    // Result register: load on a frame end, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && frame_end) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && frame_end) begin
            r_out <= result;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_frame_silent    = r_out.frame_silent;
    assign o_start_recording = r_out.start_recording;
    assign o_keep_frame      = r_out.keep_frame;
    assign o_stop_recording  = r_out.stop_recording;
    assign o_loud_count      = r_out.loud_count;

    // A stop only ends a kept frame, and a start needs a loud frame
    `FSRG_ASSERT_IMPLIES(a_stop_kept, i_clk, i_rst_n, o_valid && o_stop_recording, o_keep_frame)
    `FSRG_ASSERT_IMPLIES(a_start_loud, i_clk, i_rst_n, o_valid && o_start_recording, !o_frame_silent && o_keep_frame)
    // A frame end processed into a busy output would lose a result
    `FSRG_ASSERT_IMPLIES(a_no_overwrite, i_clk, i_rst_n, step && frame_end, slot_free)
    // A held result stays presented until taken
    `FSRG_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, r_out_valid && !i_ready, r_out_valid)

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the frame silence record gate. A directed table
// covers the sample extremes, the zero register settings, mid-frame length
// changes and recording start/stop; randomised phases then vary every
// register and the loudness of the stream, with random idling on both sides.
// Every decision is checked field by field against the table or an in-bench predictor.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fsrg_pkg::*;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_ready;
    logic signed [15:0]     i_sample;
    logic                   o_valid;
    logic                   i_ready;
    logic                   o_frame_silent;
    logic                   o_start_recording;
    logic                   o_keep_frame;
    logic                   o_stop_recording;
    logic [15:0]            o_loud_count;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    frame_silence_record_gate_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_sample          (i_sample),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_frame_silent    (o_frame_silent),
        .o_start_recording (o_start_recording),
        .o_keep_frame      (o_keep_frame),
        .o_stop_recording  (o_stop_recording),
        .o_loud_count      (o_loud_count),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    // Directed table row: either a register write or one sample
    typedef struct {
        bit                 is_reg;
        t_cfg_index         sel;
        logic [15:0]        val;
        logic signed [15:0] smp;
        bit                 typed;
        t_result            want;
    } t_script_row;

    // Predictor copy of the registers and the gate state
    t_cfg        gate_cfg;
    logic [15:0] frame_pos;
    logic [15:0] loud_acc;
    logic        rec_on;
    logic [7:0]  quiet_frames;

    t_result     pending_decisions[$];
    t_script_row script[$];
    int          decision_errors;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Guard against a hung run
    initial begin
        #6000000;
        $display("TEST FAILED");
        $finish;
    end

    // Append one row to the directed table
    function automatic void add_row(input t_script_row r);
        script.insert(script.size(), r);
    endfunction

    // Append one expected decision to the tail of the queue
    function automatic void expect_decision(input t_result d);
        pending_decisions.insert(pending_decisions.size(), d);
    endfunction

    // Advance the gate by one sample; return 1 when a frame closes
    function automatic bit gate_frame_decision(input logic signed [15:0] smp,
                                               output t_result dec);
        logic [16:0] mag;
        logic [16:0] taken;
        logic        quiet;
        dec = '0;
        mag = smp[15] ? (17'h10000 - {1'b0, smp[15:0]}) : {1'b0, smp[15:0]};
        if (mag >= {2'b00, gate_cfg.loud_threshold} && loud_acc != 16'hFFFF)
            loud_acc = loud_acc + 16'd1;
        taken = {1'b0, frame_pos} + 17'd1;
        if (taken < {1'b0, gate_cfg.frame_length}) begin
            frame_pos = taken[15:0];
            return 1'b0;
        end
        dec.loud_count = loud_acc;
        frame_pos = '0;
        loud_acc  = '0;
        quiet = (dec.loud_count < gate_cfg.min_loud_count);
        dec.frame_silent = quiet;
        // Idle and loud: open a recording
        if (!rec_on && !quiet) begin
            rec_on = 1'b1;
            quiet_frames = '0;
            dec.start_recording = 1'b1;
        end
        // Recording: keep the frame, count silent ones towards the hangover
        if (rec_on) begin
            dec.keep_frame = 1'b1;
            if (quiet) begin
                if (quiet_frames != 8'hFF)
                    quiet_frames = quiet_frames + 8'd1;
                if (quiet_frames >= gate_cfg.stop_after_silent) begin
                    rec_on = 1'b0;
                    dec.stop_recording = 1'b1;
                end
            end
        end
        return 1'b1;
    endfunction

    // Draw a sample that is loud or quiet against the current threshold
    function automatic logic signed [15:0] make_sample(input bit loud);
        logic [16:0] thr;
        logic [16:0] mag;
        logic [15:0] raw;
        if ($urandom_range(0, 99) < 8) begin
            raw = 16'($urandom);
            return raw;
        end
        thr = {2'b00, gate_cfg.loud_threshold};
        if (loud || thr == 0)
            mag = 17'($urandom_range(thr, 32768));
        else
            mag = 17'($urandom_range(0, thr - 1));
        if (mag == 17'h08000)
            return 16'sh8000;
        raw = mag[15:0];
        return $urandom_range(0, 1) ? -raw : raw;
    endfunction

    function automatic void script_reg(input t_cfg_index sel, input logic [15:0] val);
        t_script_row r;
        r = '{is_reg: 1'b1, sel: sel, val: val, smp: '0, typed: 1'b0, want: '0};
        add_row(r);
    endfunction

    function automatic void script_smp(input logic signed [15:0] smp);
        t_script_row r;
        r = '{is_reg: 1'b0, sel: CFG_LOUD_THRESHOLD, val: '0, smp: smp, typed: 1'b0,
              want: '0};
        add_row(r);
    endfunction

    // flags: silent, start, keep, stop
    function automatic void script_chk(input logic signed [15:0] smp,
                                       input logic [3:0] flags, input logic [15:0] cnt);
        t_script_row r;
        r = '{is_reg: 1'b0, sel: CFG_LOUD_THRESHOLD, val: '0, smp: smp, typed: 1'b1,
              want: t_result'({flags, cnt})};
        add_row(r);
    endfunction

    // Write one register and mirror it in the predictor
    task automatic set_gate_reg(input t_cfg_index sel, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data  <= val;
        case (sel)
            CFG_LOUD_THRESHOLD:    gate_cfg.loud_threshold    = val[14:0];
            CFG_FRAME_LENGTH:      gate_cfg.frame_length      = val;
            CFG_MIN_LOUD_COUNT:    gate_cfg.min_loud_count    = val;
            CFG_STOP_AFTER_SILENT: gate_cfg.stop_after_silent = val[7:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Hold until every decision is in and the last sample has left the pipeline
    task automatic drain_gate();
        while (pending_decisions.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Offer one sample after a gap and record what it should produce
    task automatic feed_sample(input logic signed [15:0] smp, input bit typed,
                               input t_result want, input int gap);
        t_result dec;
        bit      closes;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= smp;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        closes = gate_frame_decision(smp, dec);
        if (typed)
            expect_decision(want);
        else if (closes)
            expect_decision(dec);
    endtask

    task automatic report_error(input string what, input t_result want, input t_result got);
        if (decision_errors < 10)
            $display({"%0t %s: expected silent=%0b start=%0b keep=%0b stop=%0b count=%0d,",
                      " got silent=%0b start=%0b keep=%0b stop=%0b count=%0d"},
                     $realtime, what, want.frame_silent, want.start_recording,
                     want.keep_frame, want.stop_recording, want.loud_count,
                     got.frame_silent, got.start_recording, got.keep_frame,
                     got.stop_recording, got.loud_count);
        decision_errors++;
    endtask

    // Result side: random stalls, compare each decision with the oldest expectation
    initial begin
        int      stall;
        bit      steady_rx;
        t_result got;
        t_result want;
        steady_rx = 1'b0;
        i_ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 19) == 0)
                steady_rx = !steady_rx;
            stall = steady_rx ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid)
                @(posedge i_clk);
            got = {o_frame_silent, o_start_recording, o_keep_frame, o_stop_recording,
                   o_loud_count};
            if (pending_decisions.size() == 0) begin
                report_error("unexpected decision", '0, got);
            end else begin
                want = pending_decisions.pop_front();
                if (got !== want)
                    report_error("decision mismatch", want, got);
            end
        end
    end

    // Stimulus
    initial begin
        int          n_random;
        int          span;
        int          loud_pct;
        int          len_eff;
        bit          steady_tx;
        logic [15:0] val;

        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_sample    = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;

        gate_cfg = '{loud_threshold: RST_LOUD_THRESHOLD, frame_length: RST_FRAME_LENGTH,
                     min_loud_count: RST_MIN_LOUD_COUNT,
                     stop_after_silent: RST_STOP_AFTER_SILENT};
        frame_pos       = '0;
        loud_acc        = '0;
        rec_on          = 1'b0;
        quiet_frames    = '0;
        decision_errors = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // One-sample frames: extremes of the sample, start and stop
        script_reg(CFG_FRAME_LENGTH, 16'd1);
        script_reg(CFG_MIN_LOUD_COUNT, 16'd1);
        script_reg(CFG_STOP_AFTER_SILENT, 16'd1);
        script_chk(16'sd0,      4'b1000, 16'd0);
        script_chk(16'sd32767,  4'b0110, 16'd1);
        script_chk(-16'sd32768, 4'b0010, 16'd1);
        script_chk(16'sd32766,  4'b1011, 16'd0);
        script_chk(-16'sd32767, 4'b0110, 16'd1);
        script_chk(-16'sd1,     4'b1011, 16'd0);
        // Zero threshold: every sample loud
        script_reg(CFG_LOUD_THRESHOLD, 16'd0);
        script_chk(16'sd0, 4'b0110, 16'd1);
        // Zero stop limit: first silent recorded frame ends the recording
        script_reg(CFG_STOP_AFTER_SILENT, 16'd0);
        script_reg(CFG_MIN_LOUD_COUNT, 16'd2);
        script_chk(16'sd0, 4'b1011, 16'd1);
        // Zero minimum count: nothing is silent
        script_reg(CFG_MIN_LOUD_COUNT, 16'd0);
        script_chk(16'sd0, 4'b0110, 16'd1);
        script_chk(16'sd5, 4'b0010, 16'd1);
        script_reg(CFG_LOUD_THRESHOLD, 16'd1);
        script_chk(16'sd0, 4'b0010, 16'd0);
        // Zero frame length behaves as length one
        script_reg(CFG_FRAME_LENGTH, 16'd0);
        script_chk(16'sd1, 4'b0010, 16'd1);
        // Three-sample frame, threshold boundary
        script_reg(CFG_LOUD_THRESHOLD, 16'd100);
        script_reg(CFG_MIN_LOUD_COUNT, 16'd2);
        script_reg(CFG_STOP_AFTER_SILENT, 16'd2);
        script_reg(CFG_FRAME_LENGTH, 16'd3);
        script_smp(16'sd100);
        script_smp(-16'sd100);
        script_chk(16'sd99, 4'b0010, 16'd2);
        // Length lowered below the position mid-frame closes it on the next sample
        script_reg(CFG_FRAME_LENGTH, 16'd10);
        script_smp(16'sd200);
        script_smp(16'sd300);
        script_smp(16'sd0);
        script_reg(CFG_FRAME_LENGTH, 16'd2);
        script_chk(16'sd0, 4'b0010, 16'd2);
        // Hangover of two silent frames
        script_reg(CFG_FRAME_LENGTH, 16'd1);
        script_reg(CFG_MIN_LOUD_COUNT, 16'd1);
        script_chk(16'sd0, 4'b1010, 16'd0);
        script_chk(16'sd0, 4'b1011, 16'd0);
        script_chk(16'sd0, 4'b1000, 16'd0);

        // Walk the table; register writes only once the gate has gone quiet
        foreach (script[i]) begin
            if (script[i].is_reg) begin
                i_valid <= 1'b0;
                drain_gate();
                set_gate_reg(script[i].sel, script[i].val);
            end else begin
                feed_sample(script[i].smp, script[i].typed, script[i].want,
                            $urandom_range(0, 7));
            end
        end
        i_valid <= 1'b0;

        // Longest hangover: one loud frame then a long run of silence
        drain_gate();
        set_gate_reg(CFG_LOUD_THRESHOLD, 16'd32767);
        set_gate_reg(CFG_FRAME_LENGTH, 16'd1);
        set_gate_reg(CFG_MIN_LOUD_COUNT, 16'd1);
        set_gate_reg(CFG_STOP_AFTER_SILENT, 16'd255);
        feed_sample(16'sd32767, 1'b0, '0, $urandom_range(0, 7));
        repeat (300)
            feed_sample(make_sample(1'b0), 1'b0, '0, $urandom_range(0, 7));
        i_valid <= 1'b0;

        // Random phases: fresh settings, then a stream of varying loudness
        n_random = 0;
        loud_pct = 50;
        while (n_random < 700) begin
            drain_gate();
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 5))
                    0:       val = 16'd0;
                    1:       val = 16'd1;
                    2:       val = 16'd32767;
                    3:       val = 16'($urandom_range(1, 2000));
                    default: val = 16'($urandom_range(1, 32767));
                endcase
                val[15] = 1'($urandom_range(0, 1));
                set_gate_reg(CFG_LOUD_THRESHOLD, val);
            end
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 19))
                    0, 1:       val = 16'd0;
                    2, 3, 4:    val = 16'($urandom_range(9, 40));
                    5:          val = 16'($urandom_range(100, 300));
                    default:    val = 16'($urandom_range(1, 8));
                endcase
                set_gate_reg(CFG_FRAME_LENGTH, val);
            end
            if ($urandom_range(0, 1)) begin
                len_eff = (gate_cfg.frame_length == 0) ? 1 : int'(gate_cfg.frame_length);
                case ($urandom_range(0, 9))
                    0:       val = 16'd0;
                    1:       val = 16'hFFFF;
                    default: val = 16'($urandom_range(0, len_eff + 1));
                endcase
                set_gate_reg(CFG_MIN_LOUD_COUNT, val);
            end
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 9))
                    0:       val = 16'd0;
                    1:       val = 16'd255;
                    default: val = 16'($urandom_range(1, 6));
                endcase
                val[15:8] = 8'($urandom);
                set_gate_reg(CFG_STOP_AFTER_SILENT, val);
            end
            steady_tx = ($urandom_range(0, 3) == 0);
            span = $urandom_range(20, 80);
            repeat (span) begin
                // Shift the loudness now and then so recordings open and close
                if ($urandom_range(0, 7) == 0)
                    loud_pct = 25 * $urandom_range(0, 4);
                feed_sample(make_sample($urandom_range(0, 99) < loud_pct), 1'b0, '0,
                            steady_tx ? 0 : $urandom_range(0, 7));
                n_random++;
            end
            i_valid <= 1'b0;
        end

        // Wait for the tail, then give the gate time to show anything stray
        drain_gate();
        repeat (20) @(posedge i_clk);
        if (pending_decisions.size() != 0) begin
            $display("%0d decisions never arrived", pending_decisions.size());
            decision_errors++;
        end
        if (decision_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/fsrg_pkg.sv
hw/rtl/fsrg_cfg_regs.sv
hw/rtl/fsrg_frame_stage.sv
hw/rtl/frame_silence_record_gate_unit.sv
tb/tb_top.sv
